// ===== sv/kat_pkg.sv =====
// Shared types and constants for the keyed accumulator table.
package kat_pkg;

  localparam int KEY_IN_W = 32;
  localparam int AMOUNT_W = 32;
  localparam int TOTAL_W  = 32;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic                       found;
    logic signed [TOTAL_W-1:0]  total;
    logic                       dropped;
  } kat_res_t;

endpackage

// ===== sv/kat_ifs.sv =====
// Request and response channel interfaces for the keyed accumulator table.
interface kat_req_if;
  import kat_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [KEY_IN_W-1:0]        key_in;
  logic signed [AMOUNT_W-1:0] amount;

  modport source (output valid, kind, key_in, amount, input ready);
  modport sink   (input valid, kind, key_in, amount, output ready);
endinterface

interface kat_rsp_if;
  import kat_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      found;
  logic signed [TOTAL_W-1:0] total;
  logic                      dropped;

  modport source (output valid, found, total, dropped, input ready);
  modport sink   (input valid, found, total, dropped, output ready);
endinterface

// ===== sv/keyed_accumulator_table_unit.sv =====
// Top level of the keyed accumulator table.
//
//  channel | dir | fields                    | transfer
//  req     | in  | kind, key_in, amount      | valid & ready
//  rsp     | out | found, total, dropped     | valid & ready
//
// An item runs from transfer to result register as a scan over the occupied entries (at
// most CAPACITY): one key RAM read per cycle through a single comparator, stopping at
// the first match, a drain of the last read, then the update.
// req.ready is high only while the sequencer is idle, which it returns to after each update;
// a new item may enter while the previous result still waits in the output register.
// A stalled rsp holds the sequencer in its update cycle; no write happens until taken.
// Reset clears the entry count and control state; RAM contents need no clearing.
module keyed_accumulator_table_unit #(
  parameter int CAPACITY   = 256,
  parameter int KEY_BITS   = 32,
  parameter int TOTAL_BITS = 32
) (
  input logic        clk,
  input logic        rst,
  kat_req_if.sink    req,
  kat_rsp_if.source  rsp
);
  import kat_pkg::*;

  localparam int AW = (CAPACITY > 1 ? $clog2(CAPACITY) : 1);

  kat_res_t              res;
  logic                  res_valid;
  logic                  res_ok;
  logic                  rd_en;
  logic [AW-1:0]         raddr;
  logic [KEY_BITS-1:0]   key_rdata;
  logic [TOTAL_BITS-1:0] tot_rdata;
  logic                  key_we;
  logic                  tot_we;
  logic [AW-1:0]         waddr;
  logic [KEY_BITS-1:0]   key_wdata;
  logic [TOTAL_BITS-1:0] tot_wdata;

  logic                  out_valid;
  kat_res_t              out_res;

  assign res_ok = !out_valid || rsp.ready;

  kat_seq #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .TOTAL_BITS (TOTAL_BITS),
    .AW         (AW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res       (res),
    .res_valid (res_valid),
    .res_ok    (res_ok),
    .rd_en     (rd_en),
    .raddr     (raddr),
    .key_rdata (key_rdata),
    .tot_rdata (tot_rdata),
    .key_we    (key_we),
    .tot_we    (tot_we),
    .waddr     (waddr),
    .key_wdata (key_wdata),
    .tot_wdata (tot_wdata)
  );

  kat_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (key_wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  kat_ram #(.WIDTH(TOTAL_BITS), .DEPTH(CAPACITY)) u_tot_ram (
    .clk   (clk),
    .we    (tot_we),
    .waddr (waddr),
    .wdata (tot_wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (tot_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.found   = out_res.found;
  assign rsp.total   = out_res.total;
  assign rsp.dropped = out_res.dropped;

endmodule

// ===== sv/kat_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/kat_seq.sv =====
// Sequencer: linear key search with one comparator, then update, insert or drop for adds; queries write nothing.
module kat_seq #(
  parameter int CAPACITY   = 256,
  parameter int KEY_BITS   = 32,
  parameter int TOTAL_BITS = 32,
  parameter int AW         = (CAPACITY > 1 ? $clog2(CAPACITY) : 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  kat_req_if.sink               req,
  output kat_pkg::kat_res_t     res,
  output logic                  res_valid,
  input  logic                  res_ok,
  output logic                  rd_en,
  output logic [AW-1:0]         raddr,
  input  logic [KEY_BITS-1:0]   key_rdata,
  input  logic [TOTAL_BITS-1:0] tot_rdata,
  output logic                  key_we,
  output logic                  tot_we,
  output logic [AW-1:0]         waddr,
  output logic [KEY_BITS-1:0]   key_wdata,
  output logic [TOTAL_BITS-1:0] tot_wdata
);
  import kat_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_ACT} state_t;

  state_t                    state;
  logic [CW-1:0]             count;
  logic [CW-1:0]             idx;
  logic                      pend;
  logic [AW-1:0]             pend_idx;
  logic                      hit;
  logic [AW-1:0]             hit_idx;
  logic [TOTAL_BITS-1:0]     hit_total;
  logic                      kind;
  logic [KEY_BITS-1:0]       key;
  logic signed [AMOUNT_W-1:0] amt;

  logic [TOTAL_BITS-1:0]     amt_ext;
  logic [TOTAL_BITS-1:0]     sum;
  logic [TOTAL_BITS-1:0]     res_tot;
  logic                      full;
  logic                      is_add;

  assign amt_ext = TOTAL_BITS'(amt);
  assign sum     = hit_total + amt_ext;
  assign full    = (count == CW'(CAPACITY));
  assign is_add  = (kind == KIND_ADD);

  assign req.ready = (state == S_IDLE);
  assign rd_en     = (state == S_SCAN) && (idx < count);
  assign raddr     = idx[AW-1:0];

  assign res_valid = (state == S_ACT) && res_ok;
  assign key_we    = res_valid && is_add && !hit && !full;
  assign tot_we    = res_valid && is_add && (hit || !full);
  assign waddr     = hit ? hit_idx : count[AW-1:0];
  assign key_wdata = key;
  assign tot_wdata = hit ? sum : amt_ext;

  always_comb begin
    if (!is_add) begin
      res_tot = hit ? hit_total : '0;
    end else if (hit) begin
      res_tot = sum;
    end else if (full) begin
      res_tot = '0;
    end else begin
      res_tot = amt_ext;
    end
    res.found   = hit;
    res.total   = TOTAL_W'(res_tot);
    res.dropped = is_add && !hit && full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      hit   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            kind  <= req.kind;
            key   <= KEY_BITS'(req.key_in);
            amt   <= req.amount;
            idx   <= '0;
            pend  <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend     <= rd_en;
          pend_idx <= idx[AW-1:0];
          if (rd_en) begin
            idx <= idx + CW'(1);
          end
          if (pend && (key_rdata == key)) begin
            hit       <= 1'b1;
            hit_idx   <= pend_idx;
            hit_total <= tot_rdata;
            state     <= S_ACT;
          end else if (!rd_en && !pend) begin
            hit   <= 1'b0;
            state <= S_ACT;
          end
        end
        S_ACT: begin
          if (res_ok) begin
            if (key_we) begin
              count <= count + CW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/kat_checker.sv =====
// Port-level checks for the keyed accumulator table, bound to the top level.
module kat_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_valid,
  input logic                              req_ready,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic                              rsp_found,
  input logic signed [kat_pkg::TOTAL_W-1:0] rsp_total,
  input logic                              rsp_dropped
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp valid dropped before transfer");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req ready high right after a transfer");

  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_dropped |-> !rsp_found && (rsp_total == '0))
    else $error("dropped result carries found or a total");

  a_rsp_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("result appeared without the sequencer busy");

endmodule

bind keyed_accumulator_table_unit kat_checker u_kat_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_found   (rsp.found),
  .rsp_total   (rsp.total),
  .rsp_dropped (rsp.dropped)
);
